// ===== hdl/rscc_pkg.sv =====
// shared types, constants and helpers for the ray segment crossing counter
package rscc_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int COUNT_WIDTH  = 16;
    localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH    = PROD_WIDTH + 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int CREDIT_WIDTH = QUEUE_AW + 1;
    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;
    typedef logic [CREDIT_WIDTH-1:0]       credit_t;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_INTERIOR  = 2'd1,
        KIND_ENDPOINT  = 2'd2,
        KIND_COLLINEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_ALONG_Y  = 2'd2
    } reg_index_t;

    typedef struct packed {
        coord_t seg_x0;
        coord_t seg_y0;
        coord_t seg_x1;
        coord_t seg_y1;
        logic   last_segment;
    } segment_t;

    typedef struct packed {
        kind_t  crossing_kind;
        count_t interior_count;
        count_t endpoint_count;
        count_t collinear_count;
        logic   any_crossing;
        logic   bad_crossing;
        logic   is_last;
    } result_t;

    typedef struct packed {
        coord_t ray_origin_x;
        coord_t ray_origin_y;
        logic   ray_along_y;
    } cfg_t;

    // classified word handed from the front to the back
    typedef struct packed {
        kind_t kind;
        logic  last;
    } class_t;

    typedef struct packed {
        logic    empty;
        credit_t count;
    } queue_status_t;

    function automatic count_t sat_inc(input count_t c);
        count_t r;
        r = (c == '1) ? c : count_t'(c + 1'b1);
        return r;
    endfunction

endpackage

// ===== hdl/rscc_front.sv =====
// front part: three stage classifier of one segment against the ray
module rscc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rscc_pkg::segment_t segment,
    input  rscc_pkg::cfg_t    cfg,
    output logic              out_valid,
    output rscc_pkg::class_t  out_word
);

    typedef struct packed {
        logic parallel;
        logic collinear;
        logic endpoint;
        logic interior;
        logic d_neg;
        logic last;
    } flags_t;

    rscc_pkg::coord_t uo, vo, u0, v0, u1, v1;
    rscc_pkg::diff_t  d_next, n_next, du_next, eu_next;
    rscc_pkg::diff_t  d_reg, n_reg, du_reg, eu_reg;
    rscc_pkg::prod_t  p1_next, p2_next, p1_reg, p2_reg;
    rscc_pkg::sum_t   sum;
    flags_t           fa_next, fa_reg, fb_reg;
    logic             va_reg, vb_reg;
    logic             ahead;

    // stage a: pick along / across axes, differences and plain compares
    always_comb
    begin
        if (cfg.ray_along_y)
        begin
            uo = cfg.ray_origin_y;
            vo = cfg.ray_origin_x;
            u0 = segment.seg_y0;
            v0 = segment.seg_x0;
            u1 = segment.seg_y1;
            v1 = segment.seg_x1;
        end
        else
        begin
            uo = cfg.ray_origin_x;
            vo = cfg.ray_origin_y;
            u0 = segment.seg_x0;
            v0 = segment.seg_y0;
            u1 = segment.seg_x1;
            v1 = segment.seg_y1;
        end
        d_next  = rscc_pkg::diff_t'(v1) - rscc_pkg::diff_t'(v0);
        n_next  = rscc_pkg::diff_t'(vo) - rscc_pkg::diff_t'(v0);
        du_next = rscc_pkg::diff_t'(u1) - rscc_pkg::diff_t'(u0);
        eu_next = rscc_pkg::diff_t'(u0) - rscc_pkg::diff_t'(uo);
        fa_next.parallel  = (v1 == v0);
        fa_next.collinear = (v1 == v0) && (v0 == vo) && ((uo < u0) || (uo < u1));
        fa_next.endpoint  = (vo == v0) || (vo == v1);
        fa_next.interior  = ((v0 < vo) && (vo < v1)) || ((v1 < vo) && (vo < v0));
        fa_next.d_neg     = (v1 < v0);
        fa_next.last      = segment.last_segment;
    end

    // stage b: the two cross products
    always_comb
    begin
        p1_next = rscc_pkg::prod_t'(n_reg) * rscc_pkg::prod_t'(du_reg);
        p2_next = rscc_pkg::prod_t'(eu_reg) * rscc_pkg::prod_t'(d_reg);
    end

    // stage c: sign of the sum, corrected for the sign of d
    always_comb
    begin
        sum   = rscc_pkg::sum_t'(p1_reg) + rscc_pkg::sum_t'(p2_reg);
        ahead = fb_reg.d_neg ? sum[rscc_pkg::SUM_WIDTH-1]
                             : (!sum[rscc_pkg::SUM_WIDTH-1] && (|sum));
        out_word.last = fb_reg.last;
        if (fb_reg.parallel)
        begin
            out_word.kind = fb_reg.collinear ? rscc_pkg::KIND_COLLINEAR
                                             : rscc_pkg::KIND_NONE;
        end
        else if (!ahead)
        begin
            out_word.kind = rscc_pkg::KIND_NONE;
        end
        else if (fb_reg.endpoint)
        begin
            out_word.kind = rscc_pkg::KIND_ENDPOINT;
        end
        else if (fb_reg.interior)
        begin
            out_word.kind = rscc_pkg::KIND_INTERIOR;
        end
        else
        begin
            out_word.kind = rscc_pkg::KIND_NONE;
        end
        out_valid = vb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        n_reg  <= n_next;
        du_reg <= du_next;
        eu_reg <= eu_next;
        fa_reg <= fa_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        fb_reg <= fa_reg;
    end

endmodule

// ===== hdl/rscc_queue.sv =====
// short queue of classified words between front and back
module rscc_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rscc_pkg::class_t        push_word,
    input  logic                    pop,
    output rscc_pkg::class_t        pop_word,
    output rscc_pkg::queue_status_t status
);

    rscc_pkg::class_t             mem [rscc_pkg::QUEUE_DEPTH];
    logic [rscc_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    rscc_pkg::credit_t            count_reg, count_next;

    always_comb
    begin
        pop_word     = mem[rd_ptr_reg];
        status.empty = (count_reg == '0);
        status.count = count_reg;
        count_next   = count_reg;
        if (push && !pop)
        begin
            count_next = rscc_pkg::credit_t'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = rscc_pkg::credit_t'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== hdl/rscc_back.sv =====
// back part: saturating totals and the result register
module rscc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  rscc_pkg::class_t queue_word,
    output logic             queue_pop,
    output rscc_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    rscc_pkg::count_t  interior_reg, endpoint_reg, collinear_reg;
    rscc_pkg::count_t  interior_next, endpoint_next, collinear_next;
    rscc_pkg::result_t result_reg, result_next;
    logic              valid_reg, valid_next;

    always_comb
    begin
        queue_pop      = !queue_empty && (!valid_reg || pop);
        interior_next  = interior_reg;
        endpoint_next  = endpoint_reg;
        collinear_next = collinear_reg;
        case (queue_word.kind)
            rscc_pkg::KIND_INTERIOR:  interior_next  = rscc_pkg::sat_inc(interior_reg);
            rscc_pkg::KIND_ENDPOINT:  endpoint_next  = rscc_pkg::sat_inc(endpoint_reg);
            rscc_pkg::KIND_COLLINEAR: collinear_next = rscc_pkg::sat_inc(collinear_reg);
            default: ;
        endcase
        result_next.crossing_kind   = queue_word.kind;
        result_next.interior_count  = interior_next;
        result_next.endpoint_count  = endpoint_next;
        result_next.collinear_count = collinear_next;
        result_next.any_crossing    = |{interior_next, endpoint_next, collinear_next};
        result_next.bad_crossing    = |{endpoint_next, collinear_next};
        result_next.is_last         = queue_word.last;
        valid_next = queue_pop || (valid_reg && !pop);
        result = result_reg;
        empty  = !valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            interior_reg  <= '0;
            endpoint_reg  <= '0;
            collinear_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (queue_pop)
            begin
                if (queue_word.last)
                begin
                    interior_reg  <= '0;
                    endpoint_reg  <= '0;
                    collinear_reg <= '0;
                end
                else
                begin
                    interior_reg  <= interior_next;
                    endpoint_reg  <= endpoint_next;
                    collinear_reg <= collinear_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== hdl/ray_segment_crossing_counter.sv =====
// top level of the ray segment crossing counter with its register port
//
// segments enter as words on a queue-like port: a word is taken at a clock
// edge where push is high and full is low. results leave the same way: the
// oldest result sits on the result port while empty is low and is taken
// at an edge where pop is high.
// the ray origin and direction sit in three registers on the apb port
// (origin x at 0x0, origin y at 0x4, direction at 0x8), which must be
// written only while no segment is in flight; the block does not
// enforce this. a taken segment passes the front classifier registers
// (compares, then the two cross products) into the queue, and the back
// part registers its result with the updated totals on popping the word.
// one segment is taken every cycle as long as results are popped; the
// front-to-back queue holds four words and full follows the words held in
// the front stages and the queue together.
// when pop stays low the result register holds, the queue fills and full
// rises; nothing is dropped. reset clears the totals, the registers, the
// queue and all valid flags. totals clear after a segment marked last.
module ray_segment_crossing_counter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  rscc_pkg::segment_t                    segment,
    output logic                                  empty,
    input  logic                                  pop,
    output rscc_pkg::result_t                     result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rscc_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [rscc_pkg::DATA_WIDTH-1:0]       pwdata,
    output logic [rscc_pkg::DATA_WIDTH-1:0]       prdata,
    output logic                                  pready
);

    rscc_pkg::cfg_t          cfg_reg;
    rscc_pkg::credit_t       used_reg, used_next;
    rscc_pkg::class_t        front_word, queue_word;
    rscc_pkg::queue_status_t queue_status;
    rscc_pkg::reg_index_t    reg_index;
    logic                    accept, front_valid, queue_pop, cfg_write;

    assign pready    = 1'b1;
    assign reg_index = rscc_pkg::reg_index_t'(paddr[rscc_pkg::ADDR_WIDTH-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign full      = (used_reg == rscc_pkg::credit_t'(rscc_pkg::QUEUE_DEPTH));
    assign accept    = push && !full;

    always_comb
    begin
        case (reg_index)
            rscc_pkg::REG_ORIGIN_X: prdata = cfg_reg.ray_origin_x;
            rscc_pkg::REG_ORIGIN_Y: prdata = cfg_reg.ray_origin_y;
            rscc_pkg::REG_ALONG_Y:
                prdata = {{(rscc_pkg::DATA_WIDTH-1){1'b0}}, cfg_reg.ray_along_y};
            default: prdata = '0;
        endcase
        used_next = used_reg;
        if (accept && !queue_pop)
        begin
            used_next = rscc_pkg::credit_t'(used_reg + 1'b1);
        end
        else if (queue_pop && !accept)
        begin
            used_next = rscc_pkg::credit_t'(used_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            if (cfg_write)
            begin
                case (reg_index)
                    rscc_pkg::REG_ORIGIN_X: cfg_reg.ray_origin_x <= pwdata;
                    rscc_pkg::REG_ORIGIN_Y: cfg_reg.ray_origin_y <= pwdata;
                    rscc_pkg::REG_ALONG_Y:  cfg_reg.ray_along_y  <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    rscc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .segment   (segment),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    rscc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_word (front_word),
        .pop       (queue_pop),
        .pop_word  (queue_word),
        .status    (queue_status)
    );

    rscc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_status.empty),
        .queue_word  (queue_word),
        .queue_pop   (queue_pop),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

`ifndef SYNTHESIS
    // words in flight never exceed the queue room
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= rscc_pkg::credit_t'(rscc_pkg::QUEUE_DEPTH))
        else $error("credit count above queue depth");

    // the queue always has room for a word leaving the front
    assert property (@(posedge clk) disable iff (!rst_n)
        front_valid |-> (queue_status.count < rscc_pkg::credit_t'(rscc_pkg::QUEUE_DEPTH))
                        || queue_pop)
        else $error("queue overflow");

    // queue words are all counted by the credit
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_status.count <= used_reg)
        else $error("queue holds words not covered by credit");

    // a popped last word leaves the next result starting from zero totals
    assert property (@(posedge clk) disable iff (!rst_n)
        (queue_pop && queue_word.last) ##1 queue_pop |=>
            (result.interior_count + result.endpoint_count + result.collinear_count) <= 1)
        else $error("totals not cleared after last segment");
`endif

endmodule
